@@ rtl/xml_token_byte_scanner_defines.svh @@
// Assertion macros for the token scanner checker.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef XML_TOKEN_BYTE_SCANNER_DEFINES_SVH
`define XML_TOKEN_BYTE_SCANNER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define XTS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define XTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/xts_pkg.sv @@
package xts_pkg;

    typedef enum logic [3:0] {
        ST_TEXT,
        ST_LT,
        ST_BANG,
        ST_BANG_DASH,
        ST_SNAME,
        ST_TAG,
        ST_ANAME,
        ST_EQ_WAIT,
        ST_Q_WAIT,
        ST_AVALUE,
        ST_SLASH,
        ST_ENAME,
        ST_COMMENT,
        ST_PI,
        ST_ERROR
    } t_scan_state;

    typedef enum logic [3:0] {
        EV_TEXT,
        EV_SNAME,
        EV_ENAME,
        EV_ESPACE,
        EV_ANAME,
        EV_AVALUE,
        EV_COMM,
        EV_PI,
        EV_OPEN,
        EV_SELF,
        EV_ETAG,
        EV_CEND,
        EV_PEND,
        EV_ADONE,
        EV_EOF,
        EV_ERR
    } t_event;

    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [1:0] HELD_MAX = 2'd2;

    typedef struct packed {
        t_event     ev;
        logic [7:0] value;
        logic       last;
    } t_result;

    // Results caused by one request: up to three, in order from entry 0.
    typedef struct packed {
        logic [1:0]          count;
        t_result [2:0]       res;
    } t_step;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

endpackage

@@ rtl/xts_stream_if.sv @@
interface xts_item_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] data_byte;

    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface xts_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_res;
    logic [7:0] byte_value;
    logic       last_of_run;

    modport source (output valid, output event_res, output byte_value, output last_of_run,
                    input ready);
    modport sink (input valid, input event_res, input byte_value, input last_of_run,
                  output ready);
endinterface

@@ rtl/xml_token_byte_scanner.sv @@
// Byte-level XML token scanner. Each request on i_item is one document byte
// (opcode 0) or the end-of-document mark (opcode 1); each request on o_result is
// one labelled event, with last_of_run set on the final event a request caused.
// A request yields zero to three events. Requests are taken one per cycle while
// each yields at most one event and the result side is ready; a request yielding
// several events holds off the next request while they drain from the three-entry
// result buffer, one event per cycle through its single output port while the
// result side is ready. A request passes the input register, then the scan logic
// into the result buffer, before its first event appears. Errors are sticky until
// the end mark, which also resets the scan state.
module xml_token_byte_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    xts_item_if.sink     i_item,
    xts_result_if.source o_result
);
    import xts_pkg::*;

    logic       r_in_valid;
    logic       r_in_opcode;
    logic [7:0] r_in_byte;

    t_step      step;
    logic       load_ok;
    logic       consume;
    logic       load;

    // Retire the held request once its events fit in the buffer; a request
    // without events retires at once
    assign consume = r_in_valid && ((step.count == 2'd0) || load_ok);
    assign load    = consume && (step.count != 2'd0);

    assign i_item.ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    // Hold the payload until the next request is taken
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_opcode <= i_item.opcode;
            r_in_byte   <= i_item.data_byte;
        end
    end

    xts_scan_core u_scan_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (consume),
        .i_opcode    (r_in_opcode),
        .i_data_byte (r_in_byte),
        .o_step      (step)
    );

    xts_result_buf u_result_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_step    (step),
        .o_load_ok (load_ok),
        .o_result  (o_result)
    );

endmodule

@@ rtl/xts_scan_core.sv @@
module xts_scan_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic          i_opcode,
    input  logic [7:0]    i_data_byte,
    output xts_pkg::t_step o_step
);
    import xts_pkg::*;

    t_scan_state r_state, n_state;
    logic [1:0]  r_held, n_held;
    logic        r_quote_single, n_quote_single;
    logic        r_nonblank, n_nonblank;

    logic [7:0]  c;
    logic        ws;

    // Shared decode for a byte following a non-empty start-tag name
    logic        name_push;
    t_event      name_ev;
    logic [7:0]  name_val;
    t_scan_state name_next;

    assign c  = i_data_byte;
    assign ws = is_ws(c);

    always_comb begin
        name_push = !(ws || c == CH_SLASH);
        name_ev   = (c == CH_GT) ? EV_OPEN : EV_SNAME;
        name_val  = (c == CH_GT) ? 8'h00 : c;
        if (ws) begin
            name_next = ST_TAG;
        end else if (c == CH_SLASH) begin
            name_next = ST_SLASH;
        end else if (c == CH_GT) begin
            name_next = ST_TEXT;
        end else begin
            name_next = ST_SNAME;
        end
    end

    // Next state
    always_comb begin
        n_state        = r_state;
        n_held         = r_held;
        n_quote_single = r_quote_single;
        n_nonblank     = r_nonblank;
        if (i_opcode) begin
            n_state        = ST_TEXT;
            n_held         = 2'd0;
            n_quote_single = 1'b0;
            n_nonblank     = 1'b0;
        end else begin
            case (r_state)
                ST_TEXT: begin
                    if (c == CH_LT) n_state = ST_LT;
                end
                ST_LT: begin
                    if (c == CH_SLASH) begin
                        n_state    = ST_ENAME;
                        n_nonblank = 1'b0;
                    end else if (c == CH_BANG) begin
                        n_state = ST_BANG;
                    end else if (c == CH_QMARK) begin
                        n_state = ST_PI;
                        n_held  = 2'd0;
                    end else if (ws || c == CH_GT) begin
                        n_state = ST_ERROR;
                        n_held  = 2'd0;
                    end else begin
                        n_state = ST_SNAME;
                    end
                end
                ST_BANG: begin
                    n_state = (c == CH_DASH) ? ST_BANG_DASH : name_next;
                end
                ST_BANG_DASH: begin
                    if (c == CH_DASH) begin
                        n_state = ST_COMMENT;
                        n_held  = 2'd0;
                    end else begin
                        n_state = name_next;
                    end
                end
                ST_SNAME: begin
                    n_state = name_next;
                end
                ST_TAG: begin
                    if (ws) begin
                        n_state = ST_TAG;
                    end else if (c == CH_GT) begin
                        n_state = ST_TEXT;
                    end else if (c == CH_SLASH) begin
                        n_state = ST_SLASH;
                    end else if (c == CH_QMARK || c == CH_EQ) begin
                        n_state = ST_ERROR;
                        n_held  = 2'd0;
                    end else begin
                        n_state = ST_ANAME;
                    end
                end
                ST_ANAME: begin
                    if (c == CH_EQ) begin
                        n_state = ST_Q_WAIT;
                    end else if (ws) begin
                        n_state = ST_EQ_WAIT;
                    end else if (c == CH_GT || c == CH_SLASH) begin
                        n_state = ST_ERROR;
                        n_held  = 2'd0;
                    end
                end
                ST_EQ_WAIT: begin
                    if (c == CH_EQ) begin
                        n_state = ST_Q_WAIT;
                    end else if (!ws) begin
                        n_state = ST_ERROR;
                        n_held  = 2'd0;
                    end
                end
                ST_Q_WAIT: begin
                    if (c == CH_DQUOTE) begin
                        n_state        = ST_AVALUE;
                        n_quote_single = 1'b0;
                    end else if (c == CH_SQUOTE) begin
                        n_state        = ST_AVALUE;
                        n_quote_single = 1'b1;
                    end else if (!ws) begin
                        n_state = ST_ERROR;
                        n_held  = 2'd0;
                    end
                end
                ST_AVALUE: begin
                    if (c == (r_quote_single ? CH_SQUOTE : CH_DQUOTE)) begin
                        n_state        = ST_TAG;
                        n_quote_single = 1'b0;
                    end
                end
                ST_SLASH: begin
                    if (c == CH_GT) begin
                        n_state = ST_TEXT;
                    end else begin
                        n_state = ST_ERROR;
                        n_held  = 2'd0;
                    end
                end
                ST_ENAME: begin
                    if (c == CH_GT) begin
                        if (r_nonblank) begin
                            n_state    = ST_TEXT;
                            n_nonblank = 1'b0;
                        end else begin
                            n_state = ST_ERROR;
                            n_held  = 2'd0;
                        end
                    end else if (!ws) begin
                        n_nonblank = 1'b1;
                    end
                end
                ST_COMMENT: begin
                    if (c == CH_DASH) begin
                        if (r_held < HELD_MAX) n_held = r_held + 2'd1;
                    end else if (c == CH_GT && r_held == HELD_MAX) begin
                        n_held  = 2'd0;
                        n_state = ST_TEXT;
                    end else begin
                        n_held = 2'd0;
                    end
                end
                ST_PI: begin
                    if (c == CH_QMARK) begin
                        n_held = 2'd1;
                    end else if (c == CH_GT && r_held != 2'd0) begin
                        n_held  = 2'd0;
                        n_state = ST_TEXT;
                    end else begin
                        n_held = 2'd0;
                    end
                end
                ST_ERROR: begin
                    n_state = ST_ERROR;
                    n_held  = 2'd0;
                end
                default: begin
                    n_state = ST_ERROR;
                    n_held  = 2'd0;
                end
            endcase
        end
    end

    // Results
    always_comb begin
        logic [1:0] cnt;
        cnt    = 2'd0;
        o_step = '0;
        if (i_opcode) begin
            o_step.res[cnt] = '{ev: (r_state == ST_TEXT) ? EV_EOF : EV_ERR,
                                value: 8'h00, last: 1'b0};
            cnt = cnt + 2'd1;
        end else begin
            case (r_state)
                ST_TEXT: begin
                    if (c != CH_LT) begin
                        o_step.res[cnt] = '{ev: EV_TEXT, value: c, last: 1'b0};
                        cnt = cnt + 2'd1;
                    end
                end
                ST_LT: begin
                    if (c == CH_SLASH || c == CH_BANG || c == CH_QMARK) begin
                        cnt = cnt;
                    end else if (ws || c == CH_GT) begin
                        o_step.res[cnt] = '{ev: EV_ERR, value: 8'h00, last: 1'b0};
                        cnt = cnt + 2'd1;
                    end else begin
                        o_step.res[cnt] = '{ev: EV_SNAME, value: c, last: 1'b0};
                        cnt = cnt + 2'd1;
                    end
                end
                ST_BANG, ST_BANG_DASH: begin
                    // Not a comment opener: release the held bang (and dash) as name bytes
                    if (c != CH_DASH) begin
                        o_step.res[cnt] = '{ev: EV_SNAME, value: CH_BANG, last: 1'b0};
                        cnt = cnt + 2'd1;
                        if (r_state == ST_BANG_DASH) begin
                            o_step.res[cnt] = '{ev: EV_SNAME, value: CH_DASH, last: 1'b0};
                            cnt = cnt + 2'd1;
                        end
                        if (name_push) begin
                            o_step.res[cnt] = '{ev: name_ev, value: name_val, last: 1'b0};
                            cnt = cnt + 2'd1;
                        end
                    end
                end
                ST_SNAME: begin
                    if (name_push) begin
                        o_step.res[cnt] = '{ev: name_ev, value: name_val, last: 1'b0};
                        cnt = cnt + 2'd1;
                    end
                end
                ST_TAG: begin
                    if (ws || c == CH_SLASH) begin
                        cnt = cnt;
                    end else if (c == CH_GT) begin
                        o_step.res[cnt] = '{ev: EV_OPEN, value: 8'h00, last: 1'b0};
                        cnt = cnt + 2'd1;
                    end else if (c == CH_QMARK || c == CH_EQ) begin
                        o_step.res[cnt] = '{ev: EV_ERR, value: 8'h00, last: 1'b0};
                        cnt = cnt + 2'd1;
                    end else begin
                        o_step.res[cnt] = '{ev: EV_ANAME, value: c, last: 1'b0};
                        cnt = cnt + 2'd1;
                    end
                end
                ST_ANAME: begin
                    if (c == CH_EQ || ws) begin
                        cnt = cnt;
                    end else if (c == CH_GT || c == CH_SLASH) begin
                        o_step.res[cnt] = '{ev: EV_ERR, value: 8'h00, last: 1'b0};
                        cnt = cnt + 2'd1;
                    end else begin
                        o_step.res[cnt] = '{ev: EV_ANAME, value: c, last: 1'b0};
                        cnt = cnt + 2'd1;
                    end
                end
                ST_EQ_WAIT: begin
                    if (!ws && c != CH_EQ) begin
                        o_step.res[cnt] = '{ev: EV_ERR, value: 8'h00, last: 1'b0};
                        cnt = cnt + 2'd1;
                    end
                end
                ST_Q_WAIT: begin
                    if (!ws && c != CH_DQUOTE && c != CH_SQUOTE) begin
                        o_step.res[cnt] = '{ev: EV_ERR, value: 8'h00, last: 1'b0};
                        cnt = cnt + 2'd1;
                    end
                end
                ST_AVALUE: begin
                    if (c == (r_quote_single ? CH_SQUOTE : CH_DQUOTE)) begin
                        o_step.res[cnt] = '{ev: EV_ADONE, value: 8'h00, last: 1'b0};
                    end else begin
                        o_step.res[cnt] = '{ev: EV_AVALUE, value: c, last: 1'b0};
                    end
                    cnt = cnt + 2'd1;
                end
                ST_SLASH: begin
                    if (c == CH_GT) begin
                        o_step.res[cnt] = '{ev: EV_SELF, value: 8'h00, last: 1'b0};
                    end else begin
                        o_step.res[cnt] = '{ev: EV_ERR, value: 8'h00, last: 1'b0};
                    end
                    cnt = cnt + 2'd1;
                end
                ST_ENAME: begin
                    if (c == CH_GT) begin
                        o_step.res[cnt] = '{ev: r_nonblank ? EV_ETAG : EV_ERR,
                                            value: 8'h00, last: 1'b0};
                    end else if (ws) begin
                        o_step.res[cnt] = '{ev: EV_ESPACE, value: c, last: 1'b0};
                    end else begin
                        o_step.res[cnt] = '{ev: EV_ENAME, value: c, last: 1'b0};
                    end
                    cnt = cnt + 2'd1;
                end
                ST_COMMENT: begin
                    if (c == CH_DASH) begin
                        if (r_held == HELD_MAX) begin
                            o_step.res[cnt] = '{ev: EV_COMM, value: CH_DASH, last: 1'b0};
                            cnt = cnt + 2'd1;
                        end
                    end else if (c == CH_GT && r_held == HELD_MAX) begin
                        o_step.res[cnt] = '{ev: EV_CEND, value: 8'h00, last: 1'b0};
                        cnt = cnt + 2'd1;
                    end else begin
                        // Flush the held dashes ahead of this byte
                        if (r_held != 2'd0) begin
                            o_step.res[cnt] = '{ev: EV_COMM, value: CH_DASH, last: 1'b0};
                            cnt = cnt + 2'd1;
                        end
                        if (r_held == HELD_MAX) begin
                            o_step.res[cnt] = '{ev: EV_COMM, value: CH_DASH, last: 1'b0};
                            cnt = cnt + 2'd1;
                        end
                        o_step.res[cnt] = '{ev: EV_COMM, value: c, last: 1'b0};
                        cnt = cnt + 2'd1;
                    end
                end
                ST_PI: begin
                    if (c == CH_GT && r_held != 2'd0) begin
                        o_step.res[cnt] = '{ev: EV_PEND, value: 8'h00, last: 1'b0};
                        cnt = cnt + 2'd1;
                    end else begin
                        if (r_held != 2'd0) begin
                            o_step.res[cnt] = '{ev: EV_PI, value: CH_QMARK, last: 1'b0};
                            cnt = cnt + 2'd1;
                        end
                        if (c != CH_QMARK) begin
                            o_step.res[cnt] = '{ev: EV_PI, value: c, last: 1'b0};
                            cnt = cnt + 2'd1;
                        end
                    end
                end
                ST_ERROR: begin
                    o_step.res[cnt] = '{ev: EV_ERR, value: 8'h00, last: 1'b0};
                    cnt = cnt + 2'd1;
                end
                default: begin
                    o_step.res[cnt] = '{ev: EV_ERR, value: 8'h00, last: 1'b0};
                    cnt = cnt + 2'd1;
                end
            endcase
        end
        for (int i = 0; i < 3; i++) begin
            o_step.res[i].last = ((2'(i) + 2'd1) == cnt);
        end
        o_step.count = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_TEXT;
            r_held         <= 2'd0;
            r_quote_single <= 1'b0;
            r_nonblank     <= 1'b0;
        end else if (i_step) begin
            r_state        <= n_state;
            r_held         <= n_held;
            r_quote_single <= n_quote_single;
            r_nonblank     <= n_nonblank;
        end
    end

endmodule

@@ rtl/xts_result_buf.sv @@
module xts_result_buf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  xts_pkg::t_step i_step,
    output logic           o_load_ok,
    xts_result_if.source   o_result
);
    import xts_pkg::*;

    t_result    r_res [3];
    logic [1:0] r_left;
    logic       pop;

    assign pop       = (r_left != 2'd0) && o_result.ready;
    // Room for a new run when empty, or once the last entry leaves in this cycle
    assign o_load_ok = (r_left == 2'd0) || ((r_left == 2'd1) && o_result.ready);

    assign o_result.valid       = (r_left != 2'd0);
    assign o_result.event_res   = r_res[0].ev;
    assign o_result.byte_value  = r_res[0].value;
    assign o_result.last_of_run = r_res[0].last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
        end else if (i_load) begin
            r_left <= i_step.count;
        end else if (pop) begin
            r_left <= r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res[0] <= i_step.res[0];
            r_res[1] <= i_step.res[1];
            r_res[2] <= i_step.res[2];
        end else if (pop) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

endmodule

@@ rtl/xts_port_checker.sv @@
`include "xml_token_byte_scanner_defines.svh"

module xts_port_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_out_event,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    logic        out_stalled;
    logic        in_stalled;
    logic        out_last_taken;
    logic [12:0] out_word;

    assign out_stalled    = i_out_valid && !i_out_ready;
    assign in_stalled     = i_in_valid && !i_in_ready;
    assign out_last_taken = i_out_valid && i_out_ready && i_out_last;
    assign out_word       = {i_out_event, i_out_byte, i_out_last};

    `XTS_ASSERT_NEXT(a_out_valid_holds, out_stalled, i_out_valid, "result dropped while stalled")
    `XTS_ASSERT_NEXT(a_out_payload_holds, out_stalled, $stable(out_word), "stalled result changed")
    `XTS_ASSERT_IMPLY(a_stall_only_on_backlog, in_stalled, i_out_valid, "stall with no result")
    `XTS_ASSERT_IMPLY(a_ready_after_last, out_last_taken, i_in_ready, "not ready after a run")

endmodule

bind xml_token_byte_scanner xts_port_checker u_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_event (o_result.event_res),
    .i_out_byte  (o_result.byte_value),
    .i_out_last  (o_result.last_of_run)
);

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import xts_pkg::*;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int LONG_HOLD     = 150;
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_ITEMS  = 100;
    localparam int MAX_REPORTS   = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;

    xts_item_if   item_ch ();
    xts_result_if res_ch ();

    xml_token_byte_scanner i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch)
    );

    always #10 i_clk = ~i_clk;

    // Tokeniser state, kept apart from the scanner.
    t_scan_state scan_st;
    logic [1:0]  held_cnt;
    logic        quote_sq;
    logic        ename_nonblank;

    // Events of the request being tokenised, then the queue of awaited events.
    t_result     step_buf [0:2];
    int          step_n;
    t_result     pending_events [$];

    int          fail_count      = 0;
    int          cycle_count     = 0;
    int          sent_items      = 0;

    // Sender and receiver pacing controls.
    bit          burst     = 1'b0;
    bit          stall_req = 1'b0;
    bit          offering  = 1'b0;
    int          next_gap  = 0;

    // ------------------------------------------------------------------
    // Tokeniser
    // ------------------------------------------------------------------
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic void emit(input t_event e, input logic [7:0] b);
        step_buf[step_n].ev    = e;
        step_buf[step_n].value = b;
        step_buf[step_n].last  = 1'b0;
        step_n++;
    endfunction

    // Enter the sticky error state with one error event.
    function automatic void trip();
        scan_st  = ST_ERROR;
        held_cnt = 2'd0;
        emit(EV_ERR, 8'h00);
    endfunction

    // Byte that follows a start-tag name which already holds at least one byte.
    function automatic void sname_tail(input logic [7:0] c);
        if (is_blank(c)) begin
            scan_st = ST_TAG;
        end else if (c == CH_SLASH) begin
            scan_st = ST_SLASH;
        end else if (c == CH_GT) begin
            scan_st = ST_TEXT;
            emit(EV_OPEN, 8'h00);
        end else begin
            scan_st = ST_SNAME;
            emit(EV_SNAME, c);
        end
    endfunction

    function automatic void tokenise(input logic op, input logic [7:0] c);
        int k;
        step_n = 0;
        if (op == OP_END) begin
            // The end mark is clean only between tokens or in text.
            if (scan_st == ST_TEXT) emit(EV_EOF, 8'h00);
            else emit(EV_ERR, 8'h00);
            scan_st        = ST_TEXT;
            held_cnt       = 2'd0;
            quote_sq       = 1'b0;
            ename_nonblank = 1'b0;
        end else begin
            case (scan_st)
                ST_TEXT: begin
                    if (c == CH_LT) scan_st = ST_LT;
                    else emit(EV_TEXT, c);
                end
                ST_LT: begin
                    if (c == CH_SLASH) begin
                        scan_st        = ST_ENAME;
                        ename_nonblank = 1'b0;
                    end else if (c == CH_BANG) begin
                        scan_st = ST_BANG;
                    end else if (c == CH_QMARK) begin
                        scan_st  = ST_PI;
                        held_cnt = 2'd0;
                    end else if (is_blank(c) || c == CH_GT) begin
                        trip();
                    end else begin
                        scan_st = ST_SNAME;
                        emit(EV_SNAME, c);
                    end
                end
                ST_BANG: begin
                    if (c == CH_DASH) begin
                        scan_st = ST_BANG_DASH;
                    end else begin
                        // Not a comment: release the held bang as a name byte.
                        emit(EV_SNAME, CH_BANG);
                        sname_tail(c);
                    end
                end
                ST_BANG_DASH: begin
                    if (c == CH_DASH) begin
                        scan_st  = ST_COMMENT;
                        held_cnt = 2'd0;
                    end else begin
                        emit(EV_SNAME, CH_BANG);
                        emit(EV_SNAME, CH_DASH);
                        sname_tail(c);
                    end
                end
                ST_SNAME: sname_tail(c);
                ST_TAG: begin
                    if (is_blank(c)) begin
                        // skip blanks between attributes
                    end else if (c == CH_GT) begin
                        scan_st = ST_TEXT;
                        emit(EV_OPEN, 8'h00);
                    end else if (c == CH_SLASH) begin
                        scan_st = ST_SLASH;
                    end else if (c == CH_QMARK || c == CH_EQ) begin
                        trip();
                    end else begin
                        scan_st = ST_ANAME;
                        emit(EV_ANAME, c);
                    end
                end
                ST_ANAME: begin
                    if (c == CH_EQ) scan_st = ST_Q_WAIT;
                    else if (is_blank(c)) scan_st = ST_EQ_WAIT;
                    else if (c == CH_GT || c == CH_SLASH) trip();
                    else emit(EV_ANAME, c);
                end
                ST_EQ_WAIT: begin
                    if (c == CH_EQ) scan_st = ST_Q_WAIT;
                    else if (!is_blank(c)) trip();
                end
                ST_Q_WAIT: begin
                    if (c == CH_DQUOTE) begin
                        scan_st  = ST_AVALUE;
                        quote_sq = 1'b0;
                    end else if (c == CH_SQUOTE) begin
                        scan_st  = ST_AVALUE;
                        quote_sq = 1'b1;
                    end else if (!is_blank(c)) begin
                        trip();
                    end
                end
                ST_AVALUE: begin
                    if (c == (quote_sq ? CH_SQUOTE : CH_DQUOTE)) begin
                        scan_st  = ST_TAG;
                        quote_sq = 1'b0;
                        emit(EV_ADONE, 8'h00);
                    end else begin
                        emit(EV_AVALUE, c);
                    end
                end
                ST_SLASH: begin
                    if (c == CH_GT) begin
                        scan_st = ST_TEXT;
                        emit(EV_SELF, 8'h00);
                    end else begin
                        trip();
                    end
                end
                ST_ENAME: begin
                    if (c == CH_GT) begin
                        if (ename_nonblank) begin
                            scan_st        = ST_TEXT;
                            ename_nonblank = 1'b0;
                            emit(EV_ETAG, 8'h00);
                        end else begin
                            trip();
                        end
                    end else if (is_blank(c)) begin
                        emit(EV_ESPACE, c);
                    end else begin
                        ename_nonblank = 1'b1;
                        emit(EV_ENAME, c);
                    end
                end
                ST_COMMENT: begin
                    if (c == CH_DASH) begin
                        // Hold up to two dashes; a third pushes one out.
                        if (held_cnt < HELD_MAX) held_cnt = held_cnt + 2'd1;
                        else emit(EV_COMM, CH_DASH);
                    end else if (c == CH_GT && held_cnt == HELD_MAX) begin
                        held_cnt = 2'd0;
                        scan_st  = ST_TEXT;
                        emit(EV_CEND, 8'h00);
                    end else begin
                        repeat (held_cnt) emit(EV_COMM, CH_DASH);
                        held_cnt = 2'd0;
                        emit(EV_COMM, c);
                    end
                end
                ST_PI: begin
                    if (c == CH_QMARK) begin
                        if (held_cnt != 2'd0) emit(EV_PI, CH_QMARK);
                        held_cnt = 2'd1;
                    end else if (c == CH_GT && held_cnt != 2'd0) begin
                        held_cnt = 2'd0;
                        scan_st  = ST_TEXT;
                        emit(EV_PEND, 8'h00);
                    end else begin
                        if (held_cnt != 2'd0) emit(EV_PI, CH_QMARK);
                        held_cnt = 2'd0;
                        emit(EV_PI, c);
                    end
                end
                default: trip();
            endcase
        end
        for (k = 0; k < step_n; k++) begin
            if (k == step_n - 1) step_buf[k].last = 1'b1;
            pending_events.push_back(step_buf[k]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    // Offer one request and hold it until accepted. The gap before the next
    // request is drawn here, so valid only drops when a gap really follows.
    task automatic send_request(input logic op, input logic [7:0] b);
        if (next_gap != 0) repeat (next_gap) @(posedge i_clk);
        item_ch.valid     <= 1'b1;
        item_ch.opcode    <= op;
        item_ch.data_byte <= b;
        offering = 1'b1;
        do @(posedge i_clk); while (!item_ch.ready);
        tokenise(op, b);
        sent_items++;
        next_gap = burst ? 0 : $urandom_range(0, 9);
        if (next_gap != 0) begin
            item_ch.valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic send_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) send_request(OP_BYTE, s[k]);
    endtask

    // Drop valid, wait for every awaited event, then let the pipeline settle.
    task automatic wait_idle();
        if (offering) begin
            item_ch.valid <= 1'b0;
            offering = 1'b0;
        end
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Random content helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] any_but(input logic [7:0] x);
        logic [7:0] r;
        do r = 8'($urandom_range(0, 255)); while (r == x);
        return r;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_special();
        case ($urandom_range(0, 11))
            0:       return CH_LT;
            1:       return CH_GT;
            2:       return CH_SLASH;
            3:       return CH_QMARK;
            4:       return CH_EQ;
            5:       return CH_BANG;
            6:       return CH_DASH;
            7:       return CH_DQUOTE;
            8:       return CH_SQUOTE;
            9:       return CH_SPACE;
            10:      return 8'($urandom_range(0, 255));
            default: return CH_LF;
        endcase
    endfunction

    // Mostly lower-case letters; now and then any byte at all.
    task automatic send_name();
        repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 4) != 0) send_request(OP_BYTE, 8'($urandom_range(8'h61, 8'h7A)));
            else send_request(OP_BYTE, 8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic t_text_extremes();
        send_request(OP_BYTE, 8'h00);
        send_request(OP_BYTE, 8'hFF);
    endtask

    // Bang followed by a dash but no second dash: a start-tag name, then a
    // single-quoted attribute and a self-close.
    task automatic t_bang_without_dashes();
        send_text("<!-x a='v'/>");
    endtask

    task automatic t_clean_eof();
        send_request(OP_END, 8'hA5);
    endtask

    // End-tag name of whitespace only: a blank event, then an error at '>'.
    task automatic t_blank_end_name();
        send_text("</\t>");
    endtask

    // Every byte in the error state errors, and so does the end mark.
    task automatic t_sticky_error();
        send_request(OP_BYTE, 8'h00);
        send_request(OP_END, 8'hFF);
    endtask

    task automatic t_stray_qmark();
        send_text("<e ?");
        send_request(OP_END, 8'h5A);
    endtask

    task automatic t_random_docs();
        int         goal;
        logic [7:0] q;
        goal = sent_items + RANDOM_ITEMS;
        while (sent_items < goal) begin
            if (scan_st == ST_ERROR && $urandom_range(0, 3) != 0) begin
                // Recover from a sticky error most of the time.
                send_request(OP_END, 8'($urandom_range(0, 255)));
            end else begin
                case ($urandom_range(0, 15))
                    0, 1: begin
                        repeat ($urandom_range(1, 4)) send_request(OP_BYTE, any_but(CH_LT));
                    end
                    2, 3, 4, 5: begin
                        send_request(OP_BYTE, CH_LT);
                        if ($urandom_range(0, 5) == 0) begin
                            send_request(OP_BYTE, CH_BANG);
                            if ($urandom_range(0, 1) == 0) send_request(OP_BYTE, CH_DASH);
                        end
                        send_name();
                        repeat ($urandom_range(0, 2)) begin
                            send_request(OP_BYTE, pick_blank());
                            send_name();
                            // Corrupt the attribute now and then.
                            if ($urandom_range(0, 7) == 0) send_request(OP_BYTE, pick_special());
                            if ($urandom_range(0, 1) == 0) send_request(OP_BYTE, pick_blank());
                            send_request(OP_BYTE, CH_EQ);
                            if ($urandom_range(0, 1) == 0) send_request(OP_BYTE, pick_blank());
                            q = ($urandom_range(0, 1) == 0) ? CH_SQUOTE : CH_DQUOTE;
                            send_request(OP_BYTE, q);
                            repeat ($urandom_range(0, 3)) send_request(OP_BYTE, any_but(q));
                            send_request(OP_BYTE, q);
                        end
                        if ($urandom_range(0, 1) == 0) send_request(OP_BYTE, pick_blank());
                        if ($urandom_range(0, 2) == 0) send_request(OP_BYTE, CH_SLASH);
                        send_request(OP_BYTE, CH_GT);
                    end
                    6, 7: begin
                        send_request(OP_BYTE, CH_LT);
                        send_request(OP_BYTE, CH_SLASH);
                        if ($urandom_range(0, 1) == 0) send_request(OP_BYTE, pick_blank());
                        send_name();
                        if ($urandom_range(0, 1) == 0) send_request(OP_BYTE, pick_blank());
                        send_request(OP_BYTE, CH_GT);
                    end
                    8, 9: begin
                        send_text("<!--");
                        repeat ($urandom_range(0, 4)) begin
                            if ($urandom_range(0, 1) == 0) send_request(OP_BYTE, CH_DASH);
                            else send_request(OP_BYTE, 8'($urandom_range(0, 255)));
                        end
                        send_text("-->");
                    end
                    10, 11: begin
                        send_text("<?");
                        repeat ($urandom_range(0, 4)) begin
                            if ($urandom_range(0, 1) == 0) send_request(OP_BYTE, CH_QMARK);
                            else send_request(OP_BYTE, 8'($urandom_range(0, 255)));
                        end
                        send_text("?>");
                    end
                    12: send_request(OP_END, 8'($urandom_range(0, 255)));
                    13: begin
                        // Truncated or malformed tag opener.
                        send_request(OP_BYTE, CH_LT);
                        repeat ($urandom_range(1, 3)) send_request(OP_BYTE, pick_special());
                    end
                    default: send_request(OP_BYTE, pick_special());
                endcase
            end
            // Switch into and out of stretches with no idling on either side.
            if ($urandom_range(0, 7) == 0) burst = !burst;
        end
        burst = 1'b0;
    endtask

    // Hold the result side off while the sender keeps offering requests, so
    // the scanner's buffer fills and it stalls the input.
    task automatic t_backpressure();
        stall_req = 1'b1;
        burst     = 1'b1;
        send_text("<v a='");
        repeat (30) send_request(OP_BYTE, any_but(CH_SQUOTE));
        send_text("'>");
        send_text("<!-z>");
        burst = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: ready pacing
    // ------------------------------------------------------------------
    initial begin : result_ready_drive
        int wait_cycles;
        res_ch.ready <= 1'b0;
        wait (i_rst_n);
        forever begin
            if (stall_req) begin
                // Long hold-off, counted here.
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                stall_req = 1'b0;
            end else begin
                wait_cycles = burst ? 0 : $urandom_range(0, 9);
                if (wait_cycles != 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (wait_cycles) @(posedge i_clk);
                end
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    // ------------------------------------------------------------------
    // Event check
    // ------------------------------------------------------------------
    task automatic log_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("%s", msg);
    endtask

    always @(posedge i_clk) begin : check_events
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_events.size() == 0) begin
                log_mismatch($sformatf("unexpected event: ev %0d byte %02h last %0b",
                                       res_ch.event_res, res_ch.byte_value,
                                       res_ch.last_of_run));
            end else begin
                want = pending_events.pop_front();
                if (res_ch.event_res !== want.ev || res_ch.byte_value !== want.value ||
                    res_ch.last_of_run !== want.last) begin
                    log_mismatch($sformatf(
                        "mismatch: want ev %0d byte %02h last %0b, got ev %0d byte %02h last %0b",
                        want.ev, want.value, want.last,
                        res_ch.event_res, res_ch.byte_value, res_ch.last_of_run));
                end
            end
        end
    end

    // Watchdog: end the run with an error report once the cycle limit is reached.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        scan_st        = ST_TEXT;
        held_cnt       = 2'd0;
        quote_sq       = 1'b0;
        ename_nonblank = 1'b0;

        i_rst_n           <= 1'b0;
        item_ch.valid     <= 1'b0;
        item_ch.opcode    <= OP_BYTE;
        item_ch.data_byte <= 8'h00;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        t_text_extremes();
        t_bang_without_dashes();
        t_clean_eof();
        t_blank_end_name();
        t_sticky_error();
        t_stray_qmark();
        wait_idle();

        t_random_docs();
        wait_idle();

        t_backpressure();
        wait_idle();

        if (fail_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
